FILE: sv/pept_pkg.sv
`timescale 1ns / 1ps
package pept_pkg;

	localparam int NUM_PE = 8;
	localparam int IDX_W  = (NUM_PE > 1) ? $clog2(NUM_PE) : 1;

	localparam int PE_W   = 3;
	localparam int ID_W   = 16;
	localparam int KIND_W = 8;
	localparam int ARCH_W = 4;
	localparam int CYC_W  = 20;
	localparam int TS_W   = 32;

	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_TICK = 1'b1;

	typedef enum logic [1:0] {
		EV_LOAD_OK  = 2'd0,
		EV_REJECT   = 2'd1,
		EV_DONE     = 2'd2,
		EV_TICK_END = 2'd3
	} ev_t;

	typedef struct packed {
		logic             capture;
		logic             load_go;
		logic             step;
		logic [IDX_W-1:0] idx;
		logic             end_go;
	} pept_cmd_t;

	typedef struct packed {
		logic hit;
	} pept_sts_t;

endpackage

FILE: sv/processing_element_pool_tracker_top.sv
`timescale 1ns / 1ps
// Load: ST_LOAD registers the result beat once the output is free, then returns to idle,
// where the next request is taken. Tick: the scan sequencer steps through every element,
// then ST_END sends the closing beat; a stalled output pauses the scan.
// A new request is accepted while the last result beat still waits at the output.
// Reset (arst_n low, asynchronous): all elements idle, tick timer zero, no beat pending.
module processing_element_pool_tracker_top import pept_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              req_type,
	input  logic [PE_W-1:0]   pe_index,
	input  logic [ID_W-1:0]   task_id,
	input  logic [KIND_W-1:0] task_kind,
	input  logic [ARCH_W-1:0] arch_sel,
	input  logic [CYC_W-1:0]  run_cycles,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [1:0]        event_res,
	output logic [PE_W-1:0]   out_pe,
	output logic [ID_W-1:0]   out_task_id,
	output logic [KIND_W-1:0] out_task_kind,
	output logic [TS_W-1:0]   time_stamp,
	output logic              last
);

	pept_cmd_t cmd;
	pept_sts_t sts;

	pept_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.req_type  (req_type),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	pept_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.req_type      (req_type),
		.pe_index      (pe_index),
		.task_id       (task_id),
		.task_kind     (task_kind),
		.arch_sel      (arch_sel),
		.run_cycles    (run_cycles),
		.event_res     (event_res),
		.out_pe        (out_pe),
		.out_task_id   (out_task_id),
		.out_task_kind (out_task_kind),
		.time_stamp    (time_stamp),
		.last          (last)
	);

endmodule

FILE: sv/pept_ctrl.sv
`timescale 1ns / 1ps
module pept_ctrl import pept_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  logic      req_type,
	output logic      out_valid,
	input  logic      out_ready,
	input  pept_sts_t sts,
	output pept_cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOAD,
		ST_SCAN,
		ST_END
	} state_t;

	state_t           state_q;
	logic             out_valid_q;
	logic [IDX_W-1:0] idx_q;
	logic             out_free;
	logic             last_idx;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign last_idx  = (idx_q == IDX_W'(NUM_PE - 1));

	always_comb begin
		cmd.capture = in_valid && in_ready;
		cmd.load_go = (state_q == ST_LOAD) && out_free;
		cmd.step    = (state_q == ST_SCAN) && out_free;
		cmd.idx     = idx_q;
		cmd.end_go  = (state_q == ST_END) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else begin
			if (cmd.load_go || cmd.end_go || (cmd.step && sts.hit))
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					if (cmd.capture) begin
						idx_q   <= '0;
						state_q <= (req_type == REQ_TICK) ? ST_SCAN : ST_LOAD;
					end
				end
				ST_LOAD: begin
					if (cmd.load_go)
						state_q <= ST_IDLE;
				end
				ST_SCAN: begin
					if (cmd.step) begin
						if (last_idx)
							state_q <= ST_END;
						else
							idx_q <= idx_q + 1'b1;
					end
				end
				ST_END: begin
					if (cmd.end_go)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

FILE: sv/pept_dp.sv
`timescale 1ns / 1ps
module pept_dp import pept_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  pept_cmd_t         cmd,
	output pept_sts_t         sts,
	input  logic              req_type,
	input  logic [PE_W-1:0]   pe_index,
	input  logic [ID_W-1:0]   task_id,
	input  logic [KIND_W-1:0] task_kind,
	input  logic [ARCH_W-1:0] arch_sel,
	input  logic [CYC_W-1:0]  run_cycles,
	output logic [1:0]        event_res,
	output logic [PE_W-1:0]   out_pe,
	output logic [ID_W-1:0]   out_task_id,
	output logic [KIND_W-1:0] out_task_kind,
	output logic [TS_W-1:0]   time_stamp,
	output logic              last
);

	logic [PE_W-1:0]   pe_q;
	logic [ID_W-1:0]   id_q;
	logic [KIND_W-1:0] kind_q;
	logic [ARCH_W-1:0] arch_q;
	logic [CYC_W-1:0]  cyc_q;
	logic [TS_W-1:0]   timer_q;

	logic              busy_q  [NUM_PE];
	logic [CYC_W-1:0]  cnt_q   [NUM_PE];
	logic [ID_W-1:0]   task_q  [NUM_PE];
	logic [KIND_W-1:0] tkind_q [NUM_PE];
	logic [ARCH_W-1:0] tarch_q [NUM_PE];

	logic [1:0]        ev_q;
	logic [PE_W-1:0]   ope_q;
	logic [ID_W-1:0]   oid_q;
	logic [KIND_W-1:0] okind_q;
	logic [TS_W-1:0]   ots_q;
	logic              olast_q;

	logic [IDX_W-1:0]  sel;
	logic              in_rng;
	logic              reject;
	logic              do_load;
	logic              live;

	assign sel     = IDX_W'(pe_q);
	assign in_rng  = (32'(pe_q) < 32'(NUM_PE));
	assign reject  = !in_rng || busy_q[sel];
	assign do_load = cmd.load_go && !reject;
	assign live    = busy_q[cmd.idx] && (cnt_q[cmd.idx] != '0);
	assign sts.hit = busy_q[cmd.idx] && (cnt_q[cmd.idx] == CYC_W'(1));

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			pe_q   <= pe_index;
			id_q   <= task_id;
			kind_q <= task_kind;
			arch_q <= arch_sel;
			cyc_q  <= run_cycles;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timer_q <= '0;
			for (int i = 0; i < NUM_PE; i++)
				busy_q[i] <= 1'b0;
		end else begin
			if (cmd.capture && req_type == REQ_TICK)
				timer_q <= timer_q + 1'b1;
			if (do_load)
				busy_q[sel] <= 1'b1;
			if (cmd.step && sts.hit)
				busy_q[cmd.idx] <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (do_load) begin
			cnt_q[sel]   <= cyc_q;
			task_q[sel]  <= id_q;
			tkind_q[sel] <= kind_q;
			tarch_q[sel] <= arch_q;
		end
		if (cmd.step && live)
			cnt_q[cmd.idx] <= cnt_q[cmd.idx] - 1'b1;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_go) begin
			ev_q    <= reject ? EV_REJECT : EV_LOAD_OK;
			ope_q   <= pe_q;
			oid_q   <= id_q;
			okind_q <= kind_q;
			ots_q   <= timer_q;
			olast_q <= 1'b1;
		end else if (cmd.step && sts.hit) begin
			ev_q    <= EV_DONE;
			ope_q   <= PE_W'(cmd.idx);
			oid_q   <= task_q[cmd.idx];
			okind_q <= tkind_q[cmd.idx];
			ots_q   <= timer_q;
			olast_q <= 1'b0;
		end else if (cmd.end_go) begin
			ev_q    <= EV_TICK_END;
			ope_q   <= '0;
			oid_q   <= '0;
			okind_q <= '0;
			ots_q   <= timer_q;
			olast_q <= 1'b1;
		end
	end

	assign event_res     = ev_q;
	assign out_pe        = ope_q;
	assign out_task_id   = oid_q;
	assign out_task_kind = okind_q;
	assign time_stamp    = ots_q;
	assign last          = olast_q;

endmodule
